### rtl/core/htfd_pkg.sv
package htfd_pkg;

  // Bus status codes that arrive with each byte
  typedef enum logic [2:0] {
    BUS_OK      = 3'd0,
    BUS_NACK    = 3'd1,
    BUS_TIMEOUT = 3'd2,
    BUS_ERROR   = 3'd3,
    BUS_PARAM   = 3'd4
  } bus_code_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NACK    = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_BUS     = 3'd3,
    ST_PARAM   = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  // Byte positions inside the six byte frame
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  localparam int PROD_T_W = 31;
  localparam int PROD_H_W = 30;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/htfd_if.sv
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [2:0] bus_code;
  logic       frame_start;

  modport source (output valid, output rx_byte, output bus_code, output frame_start,
                  input ready);
  modport sink (input valid, input rx_byte, input bus_code, input frame_start,
                output ready);
endinterface

interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;

  modport source (output valid, output status, output temperature_centi,
                  output humidity_centi, input ready);
  modport sink (input valid, input status, input temperature_centi,
                input humidity_centi, output ready);
endinterface

### rtl/core/humidity_temp_frame_decoder.sv
// Measurement frame decoder for a temperature and humidity sensor.
//
// in_ch  : one transaction per frame byte (rx_byte, bus_code, frame_start).
//          frame_start marks byte 0 of a new frame; a nonzero bus_code aborts
//          the frame and yields an error result at once.
// out_ch : one transaction per finished or aborted frame: status, temperature
//          in hundredths of a degree and humidity in hundredths of a percent.
//          Conversion fields read zero unless status is ok.
//
// Throughput: one byte per cycle while in_ch is ready. A result for the byte
// that ends the frame passes through the multiply stage register, then a
// divide-by-65535 stage feeding the output register, to out_ch.
// Reset (synchronous, rst_n low) empties both stages and starts a fresh frame.
// When the receiver stalls, results hold in the output register and the
// multiply stage; in_ch stays ready while either stage can still advance,
// so bytes that end no frame keep flowing until both stages are full.
module humidity_temp_frame_decoder (
  input  logic clk,
  input  logic rst_n,
  htfd_in_if.sink    in_ch,
  htfd_out_if.source out_ch
);
  import htfd_pkg::*;

  // Frame state
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] raw_t_r, raw_t_nxt;
  logic [15:0] raw_h_r, raw_h_nxt;
  logic        fail_r, fail_nxt;

  // Multiply stage
  logic                s1_valid_r;
  status_t             s1_status_r, s1_status_nxt;
  logic [PROD_T_W-1:0] s1_prod_t_r;
  logic [PROD_H_W-1:0] s1_prod_h_r;

  // Output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic signed [14:0] out_temp_r;
  logic        [13:0] out_hum_r;

  logic accept, emit, s1_adv, out_load;

  // Effective state after an optional restart
  logic        restart;
  logic [2:0]  pos_e;
  logic [7:0]  crc_e;
  logic [15:0] raw_t_e, raw_h_e;
  logic        fail_e;

  // Divide-by-65535 stage
  logic [31:0] sum_t, sum_h;
  logic [14:0] quo_t;
  logic [13:0] quo_h;

  // Advance each stage when the one after it has room
  assign out_load    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;
  assign accept      = in_ch.valid && in_ch.ready;

  assign restart = in_ch.frame_start || (pos_r > POS_HUM_CRC);
  assign pos_e   = restart ? POS_TEMP_HI : pos_r;
  assign crc_e   = restart ? CRC_INIT : crc_r;
  assign raw_t_e = restart ? 16'd0 : raw_t_r;
  assign raw_h_e = restart ? 16'd0 : raw_h_r;
  assign fail_e  = restart ? 1'b0 : fail_r;

  always_comb begin
    pos_nxt       = pos_e;
    crc_nxt       = crc_e;
    raw_t_nxt     = raw_t_e;
    raw_h_nxt     = raw_h_e;
    fail_nxt      = fail_e;
    emit          = 1'b0;
    s1_status_nxt = ST_OK;

    if (in_ch.bus_code != BUS_OK) begin
      // Abort the frame and report the bus error
      emit = 1'b1;
      case (in_ch.bus_code)
        BUS_NACK:    s1_status_nxt = ST_NACK;
        BUS_TIMEOUT: s1_status_nxt = ST_TIMEOUT;
        BUS_ERROR:   s1_status_nxt = ST_BUS;
        default:     s1_status_nxt = ST_PARAM;
      endcase
    end else begin
      unique case (pos_e) inside
        POS_TEMP_HI, POS_TEMP_LO: begin
          raw_t_nxt = {raw_t_e[7:0], in_ch.rx_byte};
          crc_nxt   = crc8_update(crc_e, in_ch.rx_byte);
        end
        POS_HUM_HI, POS_HUM_LO: begin
          raw_h_nxt = {raw_h_e[7:0], in_ch.rx_byte};
          crc_nxt   = crc8_update(crc_e, in_ch.rx_byte);
        end
        default: begin
          // Check byte of a group
          if (crc_e != in_ch.rx_byte) begin
            fail_nxt = 1'b1;
          end
          crc_nxt = CRC_INIT;
        end
      endcase
      if (pos_e == POS_HUM_CRC) begin
        emit          = 1'b1;
        s1_status_nxt = fail_nxt ? ST_CRC : ST_OK;
      end else begin
        pos_nxt = pos_e + 3'd1;
      end
    end

    if (emit) begin
      pos_nxt   = POS_TEMP_HI;
      crc_nxt   = CRC_INIT;
      raw_t_nxt = 16'd0;
      raw_h_nxt = 16'd0;
      fail_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_TEMP_HI;
      crc_r   <= CRC_INIT;
      raw_t_r <= 16'd0;
      raw_h_r <= 16'd0;
      fail_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      raw_t_r <= raw_t_nxt;
      raw_h_r <= raw_h_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // Multiply stage: the raw words are complete in the state registers by
  // the time the last check byte arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept && emit) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_status_r <= s1_status_nxt;
      s1_prod_t_r <= PROD_T_W'(raw_t_r) * PROD_T_W'(TEMP_SCALE);
      s1_prod_h_r <= PROD_H_W'(raw_h_r) * PROD_H_W'(HUM_SCALE);
    end
  end

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays
  // below 65536
  assign sum_t = 32'(s1_prod_t_r) + 32'(s1_prod_t_r >> 16) + 32'd1;
  assign sum_h = 32'(s1_prod_h_r) + 32'(s1_prod_h_r >> 16) + 32'd1;
  assign quo_t = sum_t[30:16];
  assign quo_h = sum_h[29:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      if (s1_status_r == ST_OK) begin
        out_temp_r <= $signed(quo_t - TEMP_OFFSET);
        out_hum_r  <= quo_h;
      end else begin
        out_temp_r <= 15'sd0;
        out_hum_r  <= 14'd0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.humidity_centi    = out_hum_r;

endmodule
